/* rtl/core/i2a_pkg.sv */
// Integer-to-ASCII formatter: shared types, kind codes and character constants.
// Used by i2a_div and integer_to_ascii_formatter_top; no dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam logic [1:0] KIND_UDEC  = 2'd0;
  localparam logic [1:0] KIND_SDEC  = 2'd1;
  localparam logic [1:0] KIND_HEX_L = 2'd2;
  localparam logic [1:0] KIND_HEX_U = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  localparam int unsigned DIGIT_DEPTH = 10;

  // reciprocal of ten, exact for any 32-bit dividend with a shift of 35
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [4:0]  field_width;
    logic        zero_pad;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_word_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base_ch;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      base_ch = upper ? CH_A_UP : CH_A_LO;
      digit_char = base_ch + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

/* rtl/core/i2a_div.sv */
// Shared divide-by-base unit: one digit and quotient per step, base ten or sixteen.
// Depends on i2a_pkg. Decimal needs load in the cycle before, to register the reciprocal product.
`timescale 1ns / 1ps

module i2a_div (
  input  logic        clk,
  input  logic        load,
  input  logic        hex,
  input  logic [31:0] x,
  output logic [31:0] quo,
  output logic [3:0]  digit
);

  localparam int unsigned QW = 32 - i2a_pkg::RECIP_SHIFT + 32;

  logic [63:0]   prod;
  logic [QW-1:0] q_r;
  logic [3:0]    q_ten_lo;

  assign prod = 64'(x) * 64'(i2a_pkg::RECIP_TEN);

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= prod[63:i2a_pkg::RECIP_SHIFT];
    end
  end

  // only the low nibble of q*10 is needed: the remainder is below ten
  assign q_ten_lo = 4'({q_r[0], 3'b000} + {q_r[2:0], 1'b0});

  always_comb begin
    if (hex) begin
      quo   = {4'd0, x[31:4]};
      digit = x[3:0];
    end else begin
      quo   = 32'(q_r);
      digit = x[3:0] - q_ten_lo;
    end
  end

endmodule

/* rtl/core/integer_to_ascii_formatter_top.sv */
// Integer-to-ASCII formatter top level: sequencer, digit store and output register.
// Depends on i2a_pkg and i2a_div.
`timescale 1ns / 1ps

// Usage
//   in_valid/in_ready/in_word carries one value with its kind (unsigned or signed
//   decimal, lower or upper hex), field width and zero-pad flag. out_valid/
//   out_ready/out_word returns one ASCII character per word, last set on the
//   final character of the run: optional '-', pad characters, then digits MSB first.
//   Digits are produced by one shared divide unit, least significant first:
//   in decimal each digit passes S_MUL (reciprocal multiply), then S_DIG
//   (remainder); in hex S_DIG alone. S_PREP then sizes the padding.
//   Characters then leave at one per cycle from the output register while
//   the receiver holds out_ready high, up to 31 of them. in_ready rises again
//   once the last character is loaded into the output register.
//   in_ready is low while an item is being worked on. If the receiver stalls,
//   the output register holds its word and the sequencer waits.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and empties
//   the output register.
module integer_to_ascii_formatter_top #(
  parameter int MAX_WIDTH = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2a_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output i2a_pkg::out_word_t out_word
);

  localparam int WCAP = (MAX_WIDTH < 31) ? MAX_WIDTH : 31;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIG  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [4:0]  wid_r, wid_nxt;
  logic [4:0]  pad_r, pad_nxt;
  logic        neg_r, neg_nxt;
  logic        hex_r, hex_nxt;
  logic        upper_r, upper_nxt;
  logic        zpad_r, zpad_nxt;
  logic        out_valid_r, out_valid_nxt;
  i2a_pkg::out_word_t out_r, out_nxt;

  logic [3:0]  dstore_r [i2a_pkg::DIGIT_DEPTH];

  logic        in_acc;
  logic        slot_free;
  logic        in_neg;
  logic [4:0]  in_wid;
  logic [31:0] quo;
  logic [3:0]  dig;
  logic [3:0]  rd_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign rd_idx    = cnt_r - 4'd1;

  assign in_neg = (in_word.kind == i2a_pkg::KIND_SDEC) && in_word.value[31];
  assign in_wid = (7'(in_word.field_width) > 7'(WCAP)) ? 5'(WCAP) : in_word.field_width;

  i2a_div u_div (
    .clk   (clk),
    .load  (state_r == S_MUL),
    .hex   (hex_r),
    .x     (rem_r),
    .quo   (quo),
    .digit (dig)
  );

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    wid_nxt       = wid_r;
    pad_nxt       = pad_r;
    neg_nxt       = neg_r;
    hex_nxt       = hex_r;
    upper_nxt     = upper_r;
    zpad_nxt      = zpad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hex_nxt   = in_word.kind[1];
          upper_nxt = (in_word.kind == i2a_pkg::KIND_HEX_U);
          zpad_nxt  = in_word.zero_pad;
          neg_nxt   = in_neg;
          rem_nxt   = in_neg ? (32'd0 - in_word.value) : in_word.value;
          // a sign takes one place of the field
          wid_nxt   = (in_neg && (in_wid != 5'd0)) ? in_wid - 5'd1 : in_wid;
          cnt_nxt   = 4'd0;
          state_nxt = in_word.kind[1] ? S_DIG : S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIG;
      end
      S_DIG: begin
        rem_nxt = quo;
        cnt_nxt = cnt_r + 4'd1;
        if (quo == 32'd0) begin
          state_nxt = S_PREP;
        end else begin
          state_nxt = hex_r ? S_DIG : S_MUL;
        end
      end
      S_PREP: begin
        pad_nxt   = (wid_r > 5'(cnt_r)) ? wid_r - 5'(cnt_r) : 5'd0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.last  = 1'b0;
          if (neg_r) begin
            out_nxt.character = i2a_pkg::CH_MINUS;
            neg_nxt           = 1'b0;
          end else if (pad_r != 5'd0) begin
            out_nxt.character = zpad_r ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
            pad_nxt           = pad_r - 5'd1;
          end else begin
            out_nxt.character = i2a_pkg::digit_char(dstore_r[rd_idx], upper_r);
            cnt_nxt           = cnt_r - 4'd1;
            if (cnt_r == 4'd1) begin
              out_nxt.last = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      cnt_r       <= 4'd0;
      pad_r       <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      pad_r       <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    wid_r   <= wid_nxt;
    hex_r   <= hex_nxt;
    upper_r <= upper_nxt;
    zpad_r  <= zpad_nxt;
    out_r   <= out_nxt;
    if (state_r == S_DIG) begin
      dstore_r[cnt_r] <= dig;
    end
  end

  // decimal remainder from the reciprocal must land below ten
  a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG && !hex_r) |-> (dig < 4'd10))
    else $error("decimal digit out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG) |-> (cnt_r < 4'd10))
    else $error("digit store overrun");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r != 4'd0))
    else $error("emitting with empty digit store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready while an item is in progress");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free && !neg_r && pad_r == 5'd0 && cnt_r == 4'd1)
      |=> (out_valid && out_word.last && in_ready))
    else $error("final character not marked");

endmodule
